>>> sv/ssm_pkg.sv
// ssm_pkg: types and constants shared by the substring match stream unit
// used by the front, queue and back modules and by the top level
`default_nettype none

package ssm_pkg;

    localparam int POS_W      = 16;
    localparam int TOTAL_W    = 17;
    localparam int LEN_W      = 4;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd2;

    // report modes, codes above MODE_LAST act as count only
    localparam logic [MODE_W-1:0] MODE_ALL    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_NONOVL = 3'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIRST  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LAST   = 3'd4;

    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // results caused by one input byte
    typedef struct packed {
        logic               has_match;
        logic               has_summary;
        logic [POS_W-1:0]   match_pos;
        logic [POS_W-1:0]   summary_pos;
        logic [TOTAL_W-1:0] total;
        logic               found;
        logic               err;
        logic               ovf;
    } t_bundle;

    typedef enum logic {
        BK_FIRST,
        BK_SUMMARY
    } t_back_state;

endpackage

`default_nettype wire

>>> sv/ssm_if.sv
// ssm_if: valid/ready channel interfaces for the byte input and the result output
// depends on nothing
`default_nettype none

interface ssm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface ssm_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [15:0] position;
    logic [16:0] match_total;
    logic        found;
    logic        empty_pattern_error;
    logic        length_overflow;
    logic        final_item;

    modport source (output valid, output item_kind, output position, output match_total,
                    output found, output empty_pattern_error, output length_overflow,
                    output final_item, input ready);
    modport sink   (input valid, input item_kind, input position, input match_total,
                    input found, input empty_pattern_error, input length_overflow,
                    input final_item, output ready);
endinterface

`default_nettype wire

>>> sv/ssm_front.sv
// ssm_front: configuration registers, byte window, parallel compare and stream counters
// depends on ssm_pkg and ssm_in_if
`default_nettype none

module ssm_front #(
    parameter int              PATTERN_MAX = 8,
    parameter longint unsigned STREAM_MAX  = 65536
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [ssm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ssm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ssm_in_if.sink                                i_in,
    input  wire logic                             i_room,
    output logic                                  o_push,
    output ssm_pkg::t_bundle                      o_bundle
);

    localparam int CNT_W = $clog2(STREAM_MAX + 1);
    localparam int WIN   = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam logic [CNT_W-1:0]          SEEN_MAX = CNT_W'(STREAM_MAX);
    localparam logic [ssm_pkg::LEN_W-1:0] LEN_CAP  = ssm_pkg::LEN_W'(PATTERN_MAX);

    logic [ssm_pkg::CFG_DATA_W-1:0] r_pattern;
    logic [ssm_pkg::LEN_W-1:0]      r_len;
    logic [ssm_pkg::MODE_W-1:0]     r_mode;

    logic [7:0]                     r_recent [WIN];
    logic [CNT_W-1:0]               r_seen;
    logic [ssm_pkg::LEN_W-1:0]      r_fill;
    logic [ssm_pkg::TOTAL_W-1:0]    r_matches;
    logic [ssm_pkg::POS_W-1:0]      r_first;
    logic [ssm_pkg::POS_W-1:0]      r_last;
    logic                           r_any;
    logic [CNT_W-1:0]               r_nas;
    logic                           r_ovf;

    logic [7:0]                     n_recent [WIN];
    logic [CNT_W-1:0]               n_seen;
    logic [ssm_pkg::LEN_W-1:0]      n_fill;
    logic [ssm_pkg::TOTAL_W-1:0]    n_matches;
    logic [ssm_pkg::POS_W-1:0]      n_first;
    logic [ssm_pkg::POS_W-1:0]      n_last;
    logic                           n_any;
    logic [CNT_W-1:0]               n_nas;
    logic                           n_ovf;

    logic [7:0]                     w [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]         len_eq;
    logic                           window_eq;
    logic [ssm_pkg::LEN_W-1:0]      len_c;
    logic [ssm_pkg::LEN_W-1:0]      fill_inc;
    logic [CNT_W-1:0]               seen_inc;
    logic [CNT_W-1:0]               start;
    logic                           err;
    logic                           in_range;
    logic                           enough;
    logic                           hit;
    logic                           report;
    logic                           accept;
    logic                           eos;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_len     <= ssm_pkg::LEN_W'(1);
            r_mode    <= ssm_pkg::MODE_ALL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ssm_pkg::CFG_PATTERN: r_pattern <= i_cfg_data;
                ssm_pkg::CFG_LENGTH:  r_len     <= i_cfg_data[ssm_pkg::LEN_W-1:0];
                ssm_pkg::CFG_MODE:    r_mode    <= i_cfg_data[ssm_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = i_room;
    assign accept     = i_in.valid && i_in.ready;
    assign eos        = i_in.end_of_stream;

    // w[j] is the byte j places back, w[0] the arriving one
    always_comb begin
        w[0] = i_in.data_byte;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            w[j] = r_recent[j-1];
        end
    end

    // one compare result per candidate pattern length
    always_comb begin
        for (int l = 0; l < PATTERN_MAX; l++) begin
            len_eq[l] = 1'b1;
            for (int k = 0; k <= l; k++) begin
                if (r_pattern[8*k +: 8] != w[l-k]) begin
                    len_eq[l] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        len_c     = (r_len > LEN_CAP) ? LEN_CAP : r_len;
        window_eq = 1'b0;
        for (int l = 0; l < PATTERN_MAX; l++) begin
            if (len_c == ssm_pkg::LEN_W'(l + 1)) begin
                window_eq = len_eq[l];
            end
        end
        err      = (r_len == '0);
        in_range = (r_seen != SEEN_MAX);
        seen_inc = r_seen + CNT_W'(1);
        fill_inc = r_fill + ssm_pkg::LEN_W'(1);
        enough   = (fill_inc >= len_c);
        start    = seen_inc - CNT_W'(len_c);
        hit      = in_range && !err && enough && window_eq &&
                   ((r_mode != ssm_pkg::MODE_NONOVL) || (start >= r_nas));
        report   = hit && ((r_mode == ssm_pkg::MODE_ALL) || (r_mode == ssm_pkg::MODE_NONOVL));
    end

    // stream state after this byte
    always_comb begin
        n_recent  = r_recent;
        n_seen    = r_seen;
        n_fill    = r_fill;
        n_matches = r_matches;
        n_first   = r_first;
        n_last    = r_last;
        n_any     = r_any;
        n_nas     = r_nas;
        n_ovf     = r_ovf;
        if (!in_range) begin
            n_ovf = 1'b1;
        end else begin
            for (int j = WIN - 1; j > 0; j--) begin
                n_recent[j] = r_recent[j-1];
            end
            n_recent[0] = i_in.data_byte;
            n_seen      = seen_inc;
            if (r_fill != LEN_CAP) begin
                n_fill = fill_inc;
            end
        end
        if (hit) begin
            n_nas = seen_inc;
            if (r_matches != '1) begin
                n_matches = r_matches + ssm_pkg::TOTAL_W'(1);
            end
            if (!r_any) begin
                n_first = ssm_pkg::POS_W'(start);
            end
            n_last = ssm_pkg::POS_W'(start);
            n_any  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < WIN; j++) begin
                r_recent[j] <= '0;
            end
            r_seen    <= '0;
            r_fill    <= '0;
            r_matches <= '0;
            r_first   <= '0;
            r_last    <= '0;
            r_any     <= 1'b0;
            r_nas     <= '0;
            r_ovf     <= 1'b0;
        end else if (accept) begin
            if (eos) begin
                for (int j = 0; j < WIN; j++) begin
                    r_recent[j] <= '0;
                end
                r_seen    <= '0;
                r_fill    <= '0;
                r_matches <= '0;
                r_first   <= '0;
                r_last    <= '0;
                r_any     <= 1'b0;
                r_nas     <= '0;
                r_ovf     <= 1'b0;
            end else begin
                r_recent  <= n_recent;
                r_seen    <= n_seen;
                r_fill    <= n_fill;
                r_matches <= n_matches;
                r_first   <= n_first;
                r_last    <= n_last;
                r_any     <= n_any;
                r_nas     <= n_nas;
                r_ovf     <= n_ovf;
            end
        end
    end

    always_comb begin
        o_push               = accept && (report || eos);
        o_bundle.has_match   = report;
        o_bundle.has_summary = eos;
        o_bundle.match_pos   = ssm_pkg::POS_W'(start);
        o_bundle.summary_pos = n_any ? ((r_mode == ssm_pkg::MODE_LAST) ? n_last : n_first)
                                     : '0;
        o_bundle.total       = n_matches;
        o_bundle.found       = n_any;
        o_bundle.err         = err;
        o_bundle.ovf         = n_ovf;
    end

    a_ovf_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !eos && (r_seen == SEEN_MAX) |=> r_ovf)
        else $error("overflow flag not set after byte past stream limit");

    a_any_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any == (r_matches != '0))
        else $error("found flag and match count disagree");

endmodule

`default_nettype wire

>>> sv/ssm_fifo.sv
// ssm_fifo: short queue of result bundles between front and back
// depends on ssm_pkg
`default_nettype none

module ssm_fifo (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  ssm_pkg::t_bundle i_data,
    input  wire logic        i_pop,
    output ssm_pkg::t_bundle o_data,
    output logic             o_full,
    output logic             o_nonempty
);

    ssm_pkg::t_bundle              r_mem [ssm_pkg::QUEUE_DEPTH];
    logic [ssm_pkg::QPTR_W-1:0]    r_wr;
    logic [ssm_pkg::QPTR_W-1:0]    r_rd;
    logic [ssm_pkg::QPTR_W:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + ssm_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + ssm_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (ssm_pkg::QPTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (ssm_pkg::QPTR_W + 1)'(1);
            end
        end
    end

    assign o_data     = r_mem[r_rd];
    assign o_full     = (r_count == (ssm_pkg::QPTR_W + 1)'(ssm_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (ssm_pkg::QPTR_W + 1)'(ssm_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> sv/ssm_back.sv
// ssm_back: turns each queued bundle into one or two result transfers
// depends on ssm_pkg and ssm_out_if
`default_nettype none

module ssm_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  ssm_pkg::t_bundle i_bundle,
    input  wire logic        i_nonempty,
    output logic             o_pop,
    ssm_out_if.source        o_out
);

    ssm_pkg::t_back_state r_state;
    ssm_pkg::t_back_state n_state;
    logic                 emit_match;
    logic                 take;

    assign emit_match = (r_state == ssm_pkg::BK_FIRST) && i_bundle.has_match;
    assign take       = o_out.valid && o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssm_pkg::BK_FIRST: begin
                if (take && emit_match && i_bundle.has_summary) begin
                    n_state = ssm_pkg::BK_SUMMARY;
                end
            end
            ssm_pkg::BK_SUMMARY: begin
                if (take) begin
                    n_state = ssm_pkg::BK_FIRST;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssm_pkg::BK_FIRST;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_out.valid               = i_nonempty;
        o_out.item_kind           = emit_match ? ssm_pkg::KIND_MATCH : ssm_pkg::KIND_SUMMARY;
        o_out.position            = emit_match ? i_bundle.match_pos : i_bundle.summary_pos;
        o_out.match_total         = i_bundle.total;
        o_out.found               = i_bundle.found;
        o_out.empty_pattern_error = i_bundle.err;
        o_out.length_overflow     = i_bundle.ovf;
        o_out.final_item          = emit_match ? !i_bundle.has_summary : 1'b1;
        o_pop                     = take && o_out.final_item;
    end

    a_summary_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssm_pkg::BK_SUMMARY) |->
            (i_nonempty && i_bundle.has_match && i_bundle.has_summary))
        else $error("summary phase without a two-result bundle at the head");

endmodule

`default_nettype wire

>>> sv/substring_match_stream_unit.sv
// Streaming substring search: takes one stream byte per transfer and compares the window
// ending at that byte against a pattern of up to PATTERN_MAX bytes, all bytes in parallel.
// One byte is accepted every clock while the 4-entry result queue has room; the compare
// and counter update happen in the accept cycle, and results appear from the next cycle.
// A byte that causes both a match and the end-of-stream summary needs two output
// transfers, so for such bytes and under back-pressure the output side sets the sustained rate.
// Configuration writes take effect on the next byte and belong between streams or while idle.
// depends on ssm_pkg, ssm_if, ssm_front, ssm_fifo and ssm_back
`default_nettype none

module substring_match_stream_unit #(
    parameter int              PATTERN_MAX = 8,
    parameter longint unsigned STREAM_MAX  = 65536
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ssm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ssm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ssm_in_if.sink                              i_in,
    ssm_out_if.source                           o_out
);

    ssm_pkg::t_bundle push_bundle;
    ssm_pkg::t_bundle head_bundle;
    logic             push;
    logic             pop;
    logic             full;
    logic             nonempty;

    ssm_front #(
        .PATTERN_MAX (PATTERN_MAX),
        .STREAM_MAX  (STREAM_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_room      (!full),
        .o_push      (push),
        .o_bundle    (push_bundle)
    );

    ssm_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (push_bundle),
        .i_pop      (pop),
        .o_data     (head_bundle),
        .o_full     (full),
        .o_nonempty (nonempty)
    );

    ssm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bundle   (head_bundle),
        .i_nonempty (nonempty),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
